@@ rtl/sfasm_pkg.sv @@
// ----------------------------------------------------------------------------
// Single-precision add/sub/mul package
// Operation codes, field constants, the unpacked operand struct and its unpack function.
// ----------------------------------------------------------------------------
package sfasm_pkg;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	localparam logic [31:0] HIDDEN_BIT = 32'h4000_0000;
	localparam logic [31:0] FRAC_FIELD = 32'h3FFF_FF80;
	localparam logic [9:0]  EXP_BIAS   = 10'd127;
	localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;

	// exponents carried as 10-bit two's complement (sums stay within range)
	typedef logic signed [9:0] exp_t;

	typedef struct packed {
		logic [31:0] frac;
		exp_t        exp;
	} unpacked_t;

	function automatic unpacked_t unpack(input logic [31:0] x);
		unpacked_t u;
		logic [31:0] f;
		f = ((x << 7) & FRAC_FIELD) | HIDDEN_BIT;
		if (x[30:0] == 31'd0) begin
			u.frac = '0;
			u.exp  = '0;
		end else begin
			u.exp  = exp_t'({2'b00, x[30:23]}) - exp_t'(EXP_BIAS);
			u.frac = x[31] ? (32'd0 - f) : f;
		end
		return u;
	endfunction

endpackage

@@ rtl/sfasm_norm.sv @@
// ----------------------------------------------------------------------------
// Normaliser and packer
// Two register stages: leading-one search and shift, then field packing.
// ----------------------------------------------------------------------------
module sfasm_norm import sfasm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld_in,
	input  logic        neg_in,
	input  logic [31:0] mag_in,
	input  exp_t        exp_in,
	output logic        vld_out,
	output logic [31:0] bits_out
);

	logic        vld_s1;
	logic        neg_s1, zero_s1;
	logic [31:0] mag_s1;
	exp_t        exp_s1;
	logic [31:0] m0;
	exp_t        e0;
	logic [4:0]  lz;
	logic [31:0] m1;
	exp_t        e1;
	logic [7:0]  ef;

	always_comb begin
		m0 = mag_in;
		e0 = exp_in;
		if (mag_in[31]) begin
			m0 = mag_in >> 1;
			e0 = exp_in + exp_t'(1);
		end
		lz = '0;
		for (int i = 0; i <= 30; i++) begin
			if (m0[i]) lz = 5'(30 - i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= neg_in;
			zero_s1 <= (mag_in == 32'd0);
			mag_s1  <= m0 << lz;
			exp_s1  <= e0 - exp_t'({5'd0, lz});
		end
	end

	always_comb begin
		m1 = mag_s1;
		e1 = exp_s1 + exp_t'(EXP_BIAS);
		ef = e1[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bits_out <= zero_s1 ? 32'd0 : {neg_s1, ef, m1[29:7]};
		end
	end

endmodule

@@ rtl/single_float_add_sub_mul.sv @@
// Five register stages lie between input transfer and result valid.
// Throughput: one operation per cycle; the whole pipeline advances together,
// held only when the result register is full and not taken.
// Reset: arst_n clears all stage valid bits asynchronously; no data is reset.
// The 32x32 magnitude product and the alignment shift each take a stage.
// ----------------------------------------------------------------------------
// Truncating single-precision add/sub/mul
// Unpack/align, combine or multiply, then normalise and pack.
// ----------------------------------------------------------------------------
module single_float_add_sub_mul import sfasm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_bits
);

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	unpacked_t ua, ub;
	exp_t      d;
	logic [31:0] fa_al, fb_al;
	logic [4:0]  sh;

	always_comb begin
		ua = unpack(operand_a);
		ub = unpack(operand_b);
		d  = ua.exp - ub.exp;
		fa_al = ua.frac;
		fb_al = ub.frac;
		if (d > 0) begin
			sh = (d > exp_t'(31)) ? 5'd31 : d[4:0];
			fb_al = 32'($signed(ub.frac) >>> sh);
		end else begin
			sh = (-d > exp_t'(31)) ? 5'd31 : 5'(-d);
			fa_al = 32'($signed(ua.frac) >>> sh);
		end
	end

	// stage 1: aligned fractions / magnitudes
	logic        vld_s1;
	op_t         op_s1;
	logic [31:0] fa_s1, fb_s1;
	exp_t        e_s1;
	logic        mneg_s1, mzero_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= op_t'(mode);
			if (mode == OP_MUL) begin
				fa_s1 <= ua.frac[31] ? 32'd0 - ua.frac : ua.frac;
				fb_s1 <= ub.frac[31] ? 32'd0 - ub.frac : ub.frac;
				e_s1  <= ua.exp + ub.exp;
			end else begin
				fa_s1 <= 32'($signed(fa_al) >>> 1);
				fb_s1 <= 32'($signed(fb_al) >>> 1);
				e_s1  <= ((d > 0) ? ua.exp : ub.exp) + exp_t'(1);
			end
			mneg_s1  <= ua.frac[31] ^ ub.frac[31];
			mzero_s1 <= (ua.frac == 32'd0) || (ub.frac == 32'd0);
		end
	end

	// stage 2: combine or multiply
	logic        vld_s2, neg_s2;
	logic [31:0] mag_s2;
	exp_t        e_s2;
	logic [31:0] r;
	logic [63:0] prod;

	always_comb begin
		r    = (op_s1 == OP_SUB) ? fa_s1 - fb_s1 : fa_s1 + fb_s1;
		prod = {fa_s1[30:0], 1'b0} * {fb_s1[30:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s2 <= e_s1;
			unique case (op_s1)
				OP_ADD, OP_SUB: begin
					neg_s2 <= r[31];
					mag_s2 <= r[31] ? 32'd0 - r : r;
				end
				OP_MUL: begin
					neg_s2 <= mneg_s1;
					mag_s2 <= mzero_s1 ? 32'd0 : prod[63:32];
				end
				default: begin
					neg_s2 <= 1'b0;
					mag_s2 <= 32'd0;
				end
			endcase
		end
	end

	// stage 3: product register before normalising (keeps multiplier alone)
	logic        vld_s3, neg_s3;
	logic [31:0] mag_s3;
	exp_t        e_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3 <= neg_s2;
			mag_s3 <= mag_s2;
			e_s3   <= e_s2;
		end
	end

	sfasm_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_s3),
		.neg_in   (neg_s3),
		.mag_in   (mag_s3),
		.exp_in   (e_s3),
		.vld_out  (out_valid),
		.bits_out (result_bits)
	);

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(en && u_norm.vld_s1 && u_norm.zero_s1) |=> (result_bits == 32'd0))
		else $error("zero magnitude did not pack as +0");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!en) |=> ($stable(vld_s1) && $stable(vld_s2) && $stable(vld_s3)))
		else $error("pipeline moved while stalled");

	a_nop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s1 && op_s1 == OP_NOP) |=> (mag_s2 == 32'd0))
		else $error("unused operation gave a nonzero magnitude");

endmodule
